// File: rtl/core/aar_pkg.sv
package aar_pkg;

  localparam int OUT_FRAC_BITS = 14;
  localparam int TRIG_STEPS    = 16;
  localparam int CORDIC_STEPS  = (TRIG_STEPS > 32) ? 32 : TRIG_STEPS;
  localparam int OUT_SHIFT     = 30 - OUT_FRAC_BITS;
  localparam int SQRT_STEPS    = 31;
  localparam int QUO_BITS      = 31;

  localparam logic signed [35:0] ONE_Q30         = 36'sd1073741824;
  localparam logic signed [31:0] ONE_Q30_W       = 32'sd1073741824;
  localparam logic signed [33:0] PI_Q30          = 34'sd3373259426;
  localparam logic signed [33:0] HALF_PI_Q30     = 34'sd1686629713;
  localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
  localparam logic signed [63:0] MUL_ROUND       = 64'sd536870912;
  localparam logic signed [35:0] OUT_ROUND       = 36'((64'd1 << OUT_SHIFT) >> 1);

  typedef struct packed {
    logic [2:0][15:0]   axis;
    logic signed [33:0] h;
    logic               neg;
    logic               zero;
    logic [61:0]        rad;
  } front_t;

  typedef struct packed {
    logic [2:0][15:0]   axis;
    logic signed [33:0] h;
    logic               neg;
    logic               zero;
    logic [31:0]        len;
  } root_t;

  typedef struct packed {
    logic [2:0][15:0]   axis;
    logic               zero;
    logic [31:0]        len;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } trig_t;

  typedef struct packed {
    logic               zero;
    logic [2:0][31:0]   u;
    logic signed [31:0] c;
    logic signed [31:0] s;
  } unit_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0][2:0][15:0] m;
    logic [3:0][15:0]      q;
  } mat_t;

  // atan(2^-i) in Q2.30
  function automatic logic [29:0] atan_q30(input int unsigned i);
    case (i)
      0:  atan_q30 = 30'd843314856;
      1:  atan_q30 = 30'd497837829;
      2:  atan_q30 = 30'd263043836;
      3:  atan_q30 = 30'd133525158;
      4:  atan_q30 = 30'd67021686;
      5:  atan_q30 = 30'd33543515;
      6:  atan_q30 = 30'd16775850;
      7:  atan_q30 = 30'd8388437;
      8:  atan_q30 = 30'd4194282;
      9:  atan_q30 = 30'd2097149;
      10: atan_q30 = 30'd1048575;
      11: atan_q30 = 30'd524287;
      12: atan_q30 = 30'd262143;
      13: atan_q30 = 30'd131071;
      14: atan_q30 = 30'd65535;
      15: atan_q30 = 30'd32767;
      16: atan_q30 = 30'd16383;
      17: atan_q30 = 30'd8191;
      18: atan_q30 = 30'd4095;
      19: atan_q30 = 30'd2047;
      20: atan_q30 = 30'd1023;
      21: atan_q30 = 30'd511;
      22: atan_q30 = 30'd255;
      23: atan_q30 = 30'd127;
      24: atan_q30 = 30'd63;
      25: atan_q30 = 30'd31;
      26: atan_q30 = 30'd15;
      27: atan_q30 = 30'd8;
      28: atan_q30 = 30'd4;
      29: atan_q30 = 30'd2;
      30: atan_q30 = 30'd1;
      default: atan_q30 = 30'd0;
    endcase
  endfunction

  // Q2.30 product, rounded half up
  function automatic logic signed [31:0] mul30(input logic signed [31:0] a,
                                               input logic signed [31:0] b);
    logic signed [63:0] p;
    p = a * b;
    p = p + MUL_ROUND;
    mul30 = p[61:30];
  endfunction

  function automatic logic signed [35:0] ext36(input logic signed [31:0] a);
    ext36 = a;
  endfunction

  // Q2.30 to output format, round half up, saturate
  function automatic logic [15:0] to_out(input logic signed [35:0] v);
    logic signed [35:0] r;
    r = (v + OUT_ROUND) >>> OUT_SHIFT;
    if (r > 36'sd32767) begin
      to_out = 16'h7fff;
    end else if (r < -36'sd32768) begin
      to_out = 16'h8000;
    end else begin
      to_out = r[15:0];
    end
  endfunction

  localparam logic [15:0] ONE_OUT = to_out(ONE_Q30);

endpackage

// File: rtl/core/axis_angle_to_rotation_matrix_top.sv
// Axis-angle to 4x4 rotation matrix, via the unit quaternion.
//
// Input stream: one word per rotation (angle Q4.12 radians, axis x/y/z at any
// common scale). Output stream: four words per rotation, rows 0..3 of the
// homogeneous matrix in Q2.14, each with one quaternion part (w,x,y,z by row).
// tlast marks row 3; tuser carries the row number and the zero-axis flag.
// A zero-length axis yields the identity and quaternion (1,0,0,0).
//
// Pipeline: 2 front stages (squares, angle fold), 31 square-root stages,
// CORDIC_STEPS CORDIC stages, 31 divider stages, 3 quaternion/matrix stages,
// then a one-word output holding register that walks the four rows.
// Throughput is set by the four output words per rotation; the pipeline
// itself takes one a cycle when the receiver does not stall it.
//
// Receiver stall: the whole pipeline holds (shared enable) and s_tready drops;
// nothing is lost or repeated. s_tready is high whenever no output word is
// pending or row 3 is being taken.
// Reset (rst, synchronous): clears all valid bits and the row counter.
module axis_angle_to_rotation_matrix_top import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // angle, axis_x, axis_y, axis_z
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // col_0, col_1, col_2, col_3, quat_part
  output logic [2:0]  m_tuser,   // row_index[1:0], zero_axis
  output logic        m_tlast
);

  logic   adv;
  logic   front_valid, root_valid, trig_valid, unit_valid, mat_valid;
  front_t front_data;
  root_t  root_data;
  trig_t  trig_data;
  unit_t  unit_data;
  mat_t   mat_data;

  logic        hold_valid;
  mat_t        hold;
  logic [1:0]  row;
  logic [15:0] col0, col1, col2, col3;

  // shared enable: advance when the holding register is free or emptying
  assign adv      = !hold_valid || (m_tready && row == 2'd3);
  assign s_tready = adv;

  aar_front u_front (
    .clk, .rst, .adv,
    .in_valid  (s_tvalid),
    .in_data   (s_tdata),
    .out_valid (front_valid),
    .out_data  (front_data)
  );

  aar_isqrt u_isqrt (
    .clk, .rst, .adv,
    .in_valid  (front_valid),
    .in_data   (front_data),
    .out_valid (root_valid),
    .out_data  (root_data)
  );

  aar_cordic u_cordic (
    .clk, .rst, .adv,
    .in_valid  (root_valid),
    .in_data   (root_data),
    .out_valid (trig_valid),
    .out_data  (trig_data)
  );

  aar_divide u_divide (
    .clk, .rst, .adv,
    .in_valid  (trig_valid),
    .in_data   (trig_data),
    .out_valid (unit_valid),
    .out_data  (unit_data)
  );

  aar_matrix u_matrix (
    .clk, .rst, .adv,
    .in_valid  (unit_valid),
    .in_data   (unit_data),
    .out_valid (mat_valid),
    .out_data  (mat_data)
  );

  // output holding register and row walker
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      row        <= 2'd0;
    end else begin
      if (hold_valid && m_tready) begin
        row <= row + 2'd1;
      end
      if (adv) begin
        hold_valid <= mat_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && mat_valid) begin
      hold <= mat_data;
    end
  end

  always_comb begin
    case (row)
      2'd0: begin
        col0 = hold.m[0][0];
        col1 = hold.m[0][1];
        col2 = hold.m[0][2];
        col3 = '0;
      end
      2'd1: begin
        col0 = hold.m[1][0];
        col1 = hold.m[1][1];
        col2 = hold.m[1][2];
        col3 = '0;
      end
      2'd2: begin
        col0 = hold.m[2][0];
        col1 = hold.m[2][1];
        col2 = hold.m[2][2];
        col3 = '0;
      end
      default: begin
        col0 = '0;
        col1 = '0;
        col2 = '0;
        col3 = ONE_OUT;
      end
    endcase
  end

  assign m_tvalid = hold_valid;
  assign m_tdata  = {hold.q[row], col3, col2, col1, col0};
  assign m_tuser  = {hold.zero, row};
  assign m_tlast  = (row == 2'd3);

endmodule

// File: rtl/core/aar_front.sv
module aar_front import aar_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        adv,
  input  logic        in_valid,
  input  logic [63:0] in_data,
  output logic        out_valid,
  output front_t      out_data
);

  logic signed [15:0] angle, ax, ay, az;
  logic signed [33:0] h_raw;
  logic signed [31:0] px, py, pz;
  logic               v1;
  logic [2:0][15:0]   axis1;
  logic [30:0]        sqx, sqy, sqz;
  logic signed [33:0] h1;
  logic               neg1;
  logic [31:0]        sumsq;

  assign angle = in_data[15:0];
  assign ax    = in_data[31:16];
  assign ay    = in_data[47:32];
  assign az    = in_data[63:48];
  assign h_raw = {angle[15], angle, 17'b0};
  assign px    = ax * ax;
  assign py    = ay * ay;
  assign pz    = az * az;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1        <= in_valid;
      out_valid <= v1;
    end
  end

  // stage 1: squares, half angle folded into +-pi/2
  always_ff @(posedge clk) begin
    if (adv) begin
      axis1 <= {az, ay, ax};
      sqx   <= px[30:0];
      sqy   <= py[30:0];
      sqz   <= pz[30:0];
      if (h_raw > HALF_PI_Q30) begin
        h1   <= h_raw - PI_Q30;
        neg1 <= 1'b1;
      end else if (h_raw < -HALF_PI_Q30) begin
        h1   <= h_raw + PI_Q30;
        neg1 <= 1'b1;
      end else begin
        h1   <= h_raw;
        neg1 <= 1'b0;
      end
    end
  end

  assign sumsq = 32'(sqx) + 32'(sqy) + 32'(sqz);

  // stage 2: length squared, radicand scaled by 2^30
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.axis <= axis1;
      out_data.h    <= h1;
      out_data.neg  <= neg1;
      out_data.zero <= (sumsq == 32'd0);
      out_data.rad  <= {sumsq, 30'b0};
    end
  end

endmodule

// File: rtl/core/aar_isqrt.sv
module aar_isqrt import aar_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   adv,
  input  logic   in_valid,
  input  front_t in_data,
  output logic   out_valid,
  output root_t  out_data
);

  logic [SQRT_STEPS-1:0] vld;
  front_t                pay [SQRT_STEPS];
  logic [61:0]           rem [SQRT_STEPS];
  logic [61:0]           res [SQRT_STEPS];

  // one result bit per stage, trial bit 2^(60-2k)
  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_stage
    localparam int B = 60 - 2 * k;
    logic        v_in;
    front_t      p_in;
    logic [61:0] rem_in, res_in;
    logic [62:0] trial;

    if (k == 0) begin : g_first
      assign v_in   = in_valid;
      assign p_in   = in_data;
      assign rem_in = in_data.rad;
      assign res_in = '0;
    end else begin : g_next
      assign v_in   = vld[k-1];
      assign p_in   = pay[k-1];
      assign rem_in = rem[k-1];
      assign res_in = res[k-1];
    end

    assign trial = {1'b0, res_in} + (63'd1 << B);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay[k] <= p_in;
        if ({1'b0, rem_in} >= trial) begin
          rem[k] <= rem_in - trial[61:0];
          res[k] <= (res_in >> 1) + (62'd1 << B);
        end else begin
          rem[k] <= rem_in;
          res[k] <= res_in >> 1;
        end
      end
    end
  end

  assign out_valid = vld[SQRT_STEPS-1];

  always_comb begin
    out_data.axis = pay[SQRT_STEPS-1].axis;
    out_data.h    = pay[SQRT_STEPS-1].h;
    out_data.neg  = pay[SQRT_STEPS-1].neg;
    out_data.zero = pay[SQRT_STEPS-1].zero;
    out_data.len  = res[SQRT_STEPS-1][31:0];
  end

endmodule

// File: rtl/core/aar_cordic.sv
module aar_cordic import aar_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  root_t in_data,
  output logic  out_valid,
  output trig_t out_data
);

  logic [CORDIC_STEPS-1:0] vld;
  root_t                   pay [CORDIC_STEPS];
  logic signed [32:0]      xr  [CORDIC_STEPS];
  logic signed [32:0]      yr  [CORDIC_STEPS];
  logic signed [33:0]      hr  [CORDIC_STEPS];
  logic signed [32:0]      cx, sy;

  // rotation mode, one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
    localparam logic signed [33:0] AT = 34'(atan_q30(i));
    logic               v_in;
    root_t              p_in;
    logic signed [32:0] x_in, y_in, dx, dy;
    logic signed [33:0] h_in;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign p_in = in_data;
      assign x_in = CORDIC_GAIN_Q30;
      assign y_in = '0;
      assign h_in = in_data.h;
    end else begin : g_next
      assign v_in = vld[i-1];
      assign p_in = pay[i-1];
      assign x_in = xr[i-1];
      assign y_in = yr[i-1];
      assign h_in = hr[i-1];
    end

    assign dx = y_in >>> i;
    assign dy = x_in >>> i;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i] <= 1'b0;
      end else if (adv) begin
        vld[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay[i] <= p_in;
        if (h_in >= 0) begin
          xr[i] <= x_in - dx;
          yr[i] <= y_in + dy;
          hr[i] <= h_in - AT;
        end else begin
          xr[i] <= x_in + dx;
          yr[i] <= y_in - dy;
          hr[i] <= h_in + AT;
        end
      end
    end
  end

  assign out_valid = vld[CORDIC_STEPS-1];
  assign cx = pay[CORDIC_STEPS-1].neg ? -xr[CORDIC_STEPS-1] : xr[CORDIC_STEPS-1];
  assign sy = pay[CORDIC_STEPS-1].neg ? -yr[CORDIC_STEPS-1] : yr[CORDIC_STEPS-1];

  always_comb begin
    out_data.axis = pay[CORDIC_STEPS-1].axis;
    out_data.zero = pay[CORDIC_STEPS-1].zero;
    out_data.len  = pay[CORDIC_STEPS-1].len;
    out_data.c    = cx[31:0];
    out_data.s    = sy[31:0];
  end

endmodule

// File: rtl/core/aar_divide.sv
module aar_divide import aar_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  trig_t in_data,
  output logic  out_valid,
  output unit_t out_data
);

  logic [QUO_BITS-1:0] vld;
  trig_t               pay [QUO_BITS];
  logic [60:0]         rem [QUO_BITS][3];
  logic [30:0]         quo [QUO_BITS][3];

  // restoring divide, |a|*2^45 / len, one quotient bit per stage, three lanes
  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    localparam int S = QUO_BITS - 1 - j;
    logic  v_in;
    trig_t p_in;

    if (j == 0) begin : g_first
      assign v_in = in_valid;
      assign p_in = in_data;
    end else begin : g_next
      assign v_in = vld[j-1];
      assign p_in = pay[j-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[j] <= 1'b0;
      end else if (adv) begin
        vld[j] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pay[j] <= p_in;
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic [60:0] r_in;
      logic [30:0] q_in;
      logic [62:0] dsr;

      if (j == 0) begin : g_first
        logic [15:0] a, mag;
        assign a    = in_data.axis[l];
        assign mag  = a[15] ? (~a + 16'd1) : a;
        assign r_in = {mag, 45'b0};
        assign q_in = '0;
      end else begin : g_next
        assign r_in = rem[j-1][l];
        assign q_in = quo[j-1][l];
      end

      assign dsr = 63'(p_in.len) << S;

      always_ff @(posedge clk) begin
        if (adv) begin
          if ({2'b0, r_in} >= dsr) begin
            rem[j][l] <= r_in - dsr[60:0];
            quo[j][l] <= q_in | (31'd1 << S);
          end else begin
            rem[j][l] <= r_in;
            quo[j][l] <= q_in;
          end
        end
      end
    end
  end

  assign out_valid = vld[QUO_BITS-1];

  always_comb begin
    out_data.zero = pay[QUO_BITS-1].zero;
    out_data.c    = pay[QUO_BITS-1].c;
    out_data.s    = pay[QUO_BITS-1].s;
    for (int l = 0; l < 3; l++) begin
      out_data.u[l] = pay[QUO_BITS-1].axis[l][15] ? -{1'b0, quo[QUO_BITS-1][l]}
                                                  :  {1'b0, quo[QUO_BITS-1][l]};
    end
  end

endmodule

// File: rtl/core/aar_matrix.sv
module aar_matrix import aar_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  adv,
  input  logic  in_valid,
  input  unit_t in_data,
  output logic  out_valid,
  output mat_t  out_data
);

  logic               vq, vp;
  logic               zq, zp;
  logic signed [31:0] qw, qx, qy, qz;
  logic signed [31:0] pw, px, py, pz;
  logic signed [31:0] xx, yy, zz, xy, xz, yz, wx, wy, wz;

  always_ff @(posedge clk) begin
    if (rst) begin
      vq        <= 1'b0;
      vp        <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vq        <= in_valid;
      vp        <= vq;
      out_valid <= vp;
    end
  end

  // quaternion; zero axis forces (1,0,0,0)
  always_ff @(posedge clk) begin
    if (adv) begin
      zq <= in_data.zero;
      if (in_data.zero) begin
        qw <= ONE_Q30_W;
        qx <= '0;
        qy <= '0;
        qz <= '0;
      end else begin
        qw <= in_data.c;
        qx <= mul30(in_data.u[0], in_data.s);
        qy <= mul30(in_data.u[1], in_data.s);
        qz <= mul30(in_data.u[2], in_data.s);
      end
    end
  end

  // pair products
  always_ff @(posedge clk) begin
    if (adv) begin
      zp <= zq;
      pw <= qw;
      px <= qx;
      py <= qy;
      pz <= qz;
      xx <= mul30(qx, qx);
      yy <= mul30(qy, qy);
      zz <= mul30(qz, qz);
      xy <= mul30(qx, qy);
      xz <= mul30(qx, qz);
      yz <= mul30(qy, qz);
      wx <= mul30(qw, qx);
      wy <= mul30(qw, qy);
      wz <= mul30(qw, qz);
    end
  end

  // matrix entries and output rounding
  always_ff @(posedge clk) begin
    if (adv) begin
      out_data.zero    <= zp;
      out_data.m[0][0] <= to_out(ONE_Q30 - (ext36(yy) <<< 1) - (ext36(zz) <<< 1));
      out_data.m[0][1] <= to_out((ext36(xy) <<< 1) - (ext36(wz) <<< 1));
      out_data.m[0][2] <= to_out((ext36(xz) <<< 1) + (ext36(wy) <<< 1));
      out_data.m[1][0] <= to_out((ext36(xy) <<< 1) + (ext36(wz) <<< 1));
      out_data.m[1][1] <= to_out(ONE_Q30 - (ext36(xx) <<< 1) - (ext36(zz) <<< 1));
      out_data.m[1][2] <= to_out((ext36(yz) <<< 1) - (ext36(wx) <<< 1));
      out_data.m[2][0] <= to_out((ext36(xz) <<< 1) - (ext36(wy) <<< 1));
      out_data.m[2][1] <= to_out((ext36(yz) <<< 1) + (ext36(wx) <<< 1));
      out_data.m[2][2] <= to_out(ONE_Q30 - (ext36(xx) <<< 1) - (ext36(yy) <<< 1));
      out_data.q[0]    <= to_out(ext36(pw));
      out_data.q[1]    <= to_out(ext36(px));
      out_data.q[2]    <= to_out(ext36(py));
      out_data.q[3]    <= to_out(ext36(pz));
    end
  end

endmodule

// File: rtl/core/aar_checker.sv
module aar_checker import aar_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [79:0] m_tdata,
  input logic [2:0]  m_tuser,
  input logic        m_tlast
);

  // stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output word changed under stall");

  // rows of one rotation come back to back, in order
  a_row_seq: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && m_tuser[1:0] == $past(m_tuser[1:0]) + 2'd1)
    else $error("row sequence broken");

  a_last_row: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tuser[1:0] == 2'd3)))
    else $error("tlast not on row 3");

  // zero axis row 0 has col_0 = 1, col_1 = 0 and w = 1
  a_zero_ident: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] && m_tuser[1:0] == 2'd0 |->
      m_tdata[15:0] == ONE_OUT && m_tdata[31:16] == 16'd0 && m_tdata[79:64] == ONE_OUT)
    else $error("zero axis not identity");

  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with empty output");

endmodule

bind axis_angle_to_rotation_matrix_top aar_checker u_checker (.*);
